/* rtl/u16u8_pkg.sv */
// Package: shared types, constants and UTF-8 encode functions for the transcoder.
`timescale 1ns / 1ps
package u16u8_pkg;

  localparam logic [15:0] HIGH_FIRST  = 16'hd800;
  localparam logic [15:0] HIGH_LAST   = 16'hdbff;
  localparam logic [15:0] LOW_FIRST   = 16'hdc00;
  localparam logic [15:0] LOW_LAST    = 16'hdfff;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] REPLACEMENT = 21'h00fffd;
  localparam logic [20:0] MAX_ONE     = 21'h00007f;
  localparam logic [20:0] MAX_TWO     = 21'h0007ff;
  localparam logic [20:0] MAX_THREE   = 21'h00ffff;
  localparam logic [7:0]  LEAD_TWO    = 8'hc0;
  localparam logic [7:0]  LEAD_THREE  = 8'he0;
  localparam logic [7:0]  LEAD_FOUR   = 8'hf0;
  localparam logic [7:0]  CONT_MARK   = 8'h80;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        prefix;   // emit U+FFFD for a dropped high surrogate first
    logic        has_cp;   // then encode cp
    logic [20:0] cp;
    logic        last;     // unit ends the string
  } job_t;

  // index of the final byte of the encoding (length minus one)
  function automatic logic [1:0] cp_last_idx(input logic [20:0] cp);
    logic [1:0] r;
    if (cp <= MAX_ONE) begin
      r = 2'd0;
    end else if (cp <= MAX_TWO) begin
      r = 2'd1;
    end else if (cp <= MAX_THREE) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    return CONT_MARK | {2'b00, bits};
  endfunction

  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] last_idx,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (last_idx)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: b = (idx == 2'd0) ? (LEAD_TWO | {3'b000, cp[10:6]}) : cont_byte(cp[5:0]);
      2'd2: begin
        unique case (idx)
          2'd0:    b = LEAD_THREE | {4'b0000, cp[15:12]};
          2'd1:    b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = LEAD_FOUR | {5'b00000, cp[20:18]};
          2'd1:    b = cont_byte(cp[17:12]);
          2'd2:    b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

/* rtl/u16u8_front.sv */
// Front end: accepts code units, pairs surrogates and queues encode jobs.
`timescale 1ns / 1ps
module u16u8_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       code_unit,
  input  logic              string_last,
  input  logic              q_full,
  output logic              q_push,
  output u16u8_pkg::job_t   q_job
);
  import u16u8_pkg::*;

  logic [9:0] held_high_bits, held_high_bits_next;
  logic       held_valid, held_valid_next;
  logic       is_high, is_low, accept;
  job_t       job;

  assign is_high  = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
  assign is_low   = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    job.prefix = 1'b0;
    job.has_cp = 1'b0;
    job.cp     = {5'd0, code_unit};
    job.last   = string_last;
    held_valid_next     = 1'b0;
    held_high_bits_next = 10'd0;
    if (held_valid && is_low) begin
      job.has_cp = 1'b1;
      job.cp     = SUPP_BASE + {1'b0, held_high_bits, code_unit[9:0]};
    end else begin
      job.prefix = held_valid;
      if (is_high) begin
        if (string_last) begin
          job.has_cp = 1'b1;
          job.cp     = REPLACEMENT;
        end else begin
          held_valid_next     = 1'b1;
          held_high_bits_next = code_unit[9:0];
        end
      end else if (is_low) begin
        job.has_cp = 1'b1;
        job.cp     = REPLACEMENT;
      end else begin
        job.has_cp = 1'b1;
      end
    end
  end

  assign q_job  = job;
  assign q_push = accept && (job.prefix || job.has_cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_high_bits <= 10'd0;
    end else if (accept) begin
      held_valid     <= held_valid_next;
      held_high_bits <= held_high_bits_next;
    end
  end

endmodule

/* rtl/u16u8_queue.sv */
// Job queue: short register FIFO between front and back ends.
`timescale 1ns / 1ps
module u16u8_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u16u8_pkg::job_t   push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output u16u8_pkg::job_t   head
);
  import u16u8_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/u16u8_back.sv */
// Back end: steps through jobs, registering a UTF-8 byte per unstalled cycle.
`timescale 1ns / 1ps
module u16u8_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  u16u8_pkg::job_t   q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        utf8_byte,
  output logic              run_last,
  output logic              string_end
);
  import u16u8_pkg::*;

  logic        prefix_done;
  logic [1:0]  idx;
  logic        in_prefix, cp_final, job_done, advance;
  logic [20:0] cur_cp;
  logic [1:0]  cur_last;

  assign in_prefix = q_head.prefix && !prefix_done;
  assign cur_cp    = in_prefix ? REPLACEMENT : q_head.cp;
  assign cur_last  = cp_last_idx(cur_cp);
  assign cp_final  = (idx == cur_last);
  assign job_done  = cp_final && (!in_prefix || !q_head.has_cp);
  assign advance   = !q_empty && (!out_valid || out_ready);
  assign q_pop     = advance && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_done <= 1'b0;
      idx         <= 2'd0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (job_done) begin
          prefix_done <= 1'b0;
          idx         <= 2'd0;
        end else if (cp_final) begin
          prefix_done <= 1'b1;
          idx         <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      utf8_byte  <= enc_byte(cur_cp, cur_last, idx);
      run_last   <= job_done;
      string_end <= job_done && q_head.last;
    end
  end

endmodule

/* rtl/utf16_to_utf8_transcoder.sv */
// Top level: UTF-16 code unit stream in, UTF-8 byte stream out.
`timescale 1ns / 1ps
// Each accepted UTF-16 code unit is classified combinationally and queued; the
// output side then produces one UTF-8 byte per cycle while a job is queued and
// m_axis_tready does not stall it. A high surrogate waiting for its pair causes
// no bytes until the next unit. A lone surrogate, or a high surrogate that ends
// the string, becomes U+FFFD. run_last marks the final byte caused by a unit;
// tlast marks the final byte of the string.
module utf16_to_utf8_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,   // string_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] utf8_byte
  output logic        m_axis_tuser,   // [0] run_last
  output logic        m_axis_tlast    // string_end
);
  import u16u8_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, head_job;

  u16u8_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .code_unit   (s_axis_tdata),
    .string_last (s_axis_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (head_job),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .utf8_byte  (m_axis_tdata),
    .run_last   (m_axis_tuser),
    .string_end (m_axis_tlast)
  );

endmodule
